// ===== design/shtp_rvr_pkg.sv =====
// Shared types and constants for the rotation-vector receiver.
// No dependencies; the receiver, parser and decode modules import this package.
package shtp_rvr_pkg;

  localparam int unsigned LEN_W     = 15;
  localparam int unsigned CAP_DEPTH = 18;
  localparam int unsigned CAP_CNT_W = $clog2(CAP_DEPTH + 1);

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 15'd300;
  localparam logic [LEN_W-1:0] HDR_BYTES         = 15'd4;
  localparam logic [LEN_W-1:0] MIN_ROT_LEN       = 15'd14;
  localparam logic [LEN_W-1:0] MIN_TS_ROT_LEN    = 15'd19;

  localparam logic [7:0] ID_TIMESTAMP   = 8'hFB;
  localparam logic [7:0] ID_ROTATION    = 8'h05;
  localparam logic [7:0] CMD_RESET_DONE = 8'h01;
  localparam logic [7:0] CH_EXEC        = 8'h01;
  localparam logic [7:0] CH_SENSOR_RPT  = 8'h03;

  typedef enum logic [2:0] {
    ST_HEADER    = 3'b001,
    ST_CHUNK_HDR = 3'b010,
    ST_PAYLOAD   = 3'b100
  } state_e;

  typedef enum logic [1:0] {
    STAT_ZERO_LEN = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_PAYLOAD  = 2'd2
  } status_e;

  typedef logic [CAP_DEPTH-1:0][7:0] cap_t;

  // Result event from the parser, valid in the cycle of the byte transfer.
  typedef struct packed {
    logic             emit;
    status_e          status;
    logic [7:0]       chan;
    logic [7:0]       seq;
    logic [LEN_W-1:0] len;
    logic             reset_done;
  } evt_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         accuracy;
    logic signed [15:0] quat_i;
    logic signed [15:0] quat_j;
    logic signed [15:0] quat_k;
    logic signed [15:0] quat_real;
  } rot_t;

  typedef struct packed {
    status_e          status;
    logic [7:0]       chan;
    logic [7:0]       seq;
    logic [LEN_W-1:0] len;
    rot_t             rot;
    logic             reset_done;
  } res_t;

endpackage

// ===== design/shtp_rvr_in_if.sv =====
// Byte stream channel into the receiver: valid/ready handshake, one byte.
// No dependencies.
interface shtp_rvr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/shtp_rvr_out_if.sv =====
// Result channel of the receiver: valid/ready handshake, one packet result.
// No dependencies.
interface shtp_rvr_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [7:0]         channel;
  logic [7:0]         sequence_res;
  logic [14:0]        data_len;
  logic               rot_valid;
  logic [1:0]         accuracy;
  logic signed [15:0] quat_i;
  logic signed [15:0] quat_j;
  logic signed [15:0] quat_k;
  logic signed [15:0] quat_real;
  logic               reset_done;

  modport source (output valid, output status, output channel, output sequence_res,
                  output data_len, output rot_valid, output accuracy, output quat_i,
                  output quat_j, output quat_k, output quat_real, output reset_done,
                  input ready);
  modport sink (input valid, input status, input channel, input sequence_res,
                input data_len, input rot_valid, input accuracy, input quat_i,
                input quat_j, input quat_k, input quat_real, input reset_done,
                output ready);
endinterface

// ===== design/shtp_rotation_vector_receiver.sv =====
// Top level of the rotation-vector receiver: parser, report decode, result register.
// Depends on shtp_rvr_pkg, shtp_rvr_in_if, shtp_rvr_out_if, shtp_rvr_parser,
// shtp_rvr_decode.
//
//   port     dir  handshake     carries
//   rx_i     in   valid/ready   rx_byte, one link byte per transfer
//   res_o    out  valid/ready   one packet result per transfer
//   cfg_*    in   write enable  max_payload (15 bits)
//
// One byte per cycle while the input is not stalled; a result appears in the result register the cycle after
// the byte that completes its packet or header.
// The result register is the only buffer: bytes that complete nothing are taken
// while a result waits, and a completing byte stalls only while that register is
// full and not being drained.
// Reset is asynchronous; afterwards the parser waits for a packet header and
// max_payload is 300.
module shtp_rotation_vector_receiver #(
  parameter int unsigned CHUNK_BYTES = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [shtp_rvr_pkg::LEN_W-1:0] cfg_wdata_i,
  shtp_rvr_in_if.sink                    rx_i,
  shtp_rvr_out_if.source                 res_o
);
  import shtp_rvr_pkg::*;

  evt_t evt;
  cap_t cap;
  rot_t rot;
  res_t res_q;
  logic res_valid_q;
  logic in_fire;
  logic load;

  assign rx_i.ready = !res_valid_q || res_o.ready || !evt.emit;
  assign in_fire    = rx_i.valid && rx_i.ready;
  assign load       = in_fire && evt.emit;

  shtp_rvr_parser #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_fire_i   (in_fire),
    .rx_byte_i   (rx_i.rx_byte),
    .evt_o       (evt),
    .cap_o       (cap)
  );

  shtp_rvr_decode u_decode (
    .evt_i (evt),
    .cap_i (cap),
    .rot_o (rot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q.status     <= evt.status;
      res_q.chan       <= evt.chan;
      res_q.seq        <= evt.seq;
      res_q.len        <= evt.len;
      res_q.rot        <= rot;
      res_q.reset_done <= evt.reset_done;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.status       = res_q.status;
  assign res_o.channel      = res_q.chan;
  assign res_o.sequence_res = res_q.seq;
  assign res_o.data_len     = res_q.len;
  assign res_o.rot_valid    = res_q.rot.valid;
  assign res_o.accuracy     = res_q.rot.accuracy;
  assign res_o.quat_i       = res_q.rot.quat_i;
  assign res_o.quat_j       = res_q.rot.quat_j;
  assign res_o.quat_k       = res_q.rot.quat_k;
  assign res_o.quat_real    = res_q.rot.quat_real;
  assign res_o.reset_done   = res_q.reset_done;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_o.ready) |-> !load)
    else $error("pending result overwritten");

  a_rot_only_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.rot.valid) |-> (res_q.status == STAT_PAYLOAD))
    else $error("rotation data on a status result");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> res_valid_q)
    else $error("result lost after load");

endmodule

// ===== design/shtp_rvr_parser.sv =====
// Header/chunk/payload state machine, payload capture and max_payload register.
// Depends on shtp_rvr_pkg.
module shtp_rvr_parser #(
  parameter int unsigned CHUNK_BYTES = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [shtp_rvr_pkg::LEN_W-1:0]   cfg_wdata_i,
  input  logic                             in_fire_i,
  input  logic [7:0]                       rx_byte_i,
  output shtp_rvr_pkg::evt_t               evt_o,
  output shtp_rvr_pkg::cap_t               cap_o
);
  import shtp_rvr_pkg::*;

  localparam int unsigned PW = $clog2(CHUNK_BYTES);
  localparam logic [PW-1:0] LAST_PAY_POS = PW'(CHUNK_BYTES - 5);

  state_e             state_q, state_d;
  logic [PW-1:0]      pos_q, pos_d;
  logic [7:0]         len_low_q, len_low_d;
  logic [LEN_W-1:0]   remaining_q, remaining_d;
  logic [LEN_W-1:0]   packet_len_q, packet_len_d;
  logic [7:0]         chan_q, chan_d;
  logic [7:0]         seq_q, seq_d;
  cap_t               cap_q, cap_d;
  logic [CAP_CNT_W-1:0] captured_q, captured_d;
  logic               reset_seen_q, reset_seen_d;
  logic [LEN_W-1:0]   max_payload_q;
  logic [LEN_W-1:0]   hlen_m4;
  logic [LEN_W-1:0]   dlen;
  evt_t               evt;

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    len_low_d    = len_low_q;
    remaining_d  = remaining_q;
    packet_len_d = packet_len_q;
    chan_d       = chan_q;
    seq_d        = seq_q;
    cap_d        = cap_q;
    captured_d   = captured_q;
    reset_seen_d = reset_seen_q;

    hlen_m4 = packet_len_q - HDR_BYTES;
    dlen    = (hlen_m4 > max_payload_q) ? max_payload_q : hlen_m4;

    evt.emit       = 1'b0;
    evt.status     = STAT_PAYLOAD;
    evt.chan       = chan_q;
    evt.seq        = seq_q;
    evt.len        = packet_len_q;
    evt.reset_done = reset_seen_q;

    unique case (state_q)
      ST_CHUNK_HDR: begin
        // drop the repeated header
        if (in_fire_i) begin
          if (pos_q == PW'(3)) begin
            state_d = ST_PAYLOAD;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + PW'(1);
          end
        end
      end

      ST_PAYLOAD: begin
        if (in_fire_i) begin
          for (int i = 0; i < CAP_DEPTH; i++) begin
            if (captured_q == CAP_CNT_W'(i)) cap_d[i] = rx_byte_i;
          end
        end
        evt.emit       = (remaining_q == LEN_W'(1));
        evt.reset_done = reset_seen_q |
                         ((chan_q == CH_EXEC) && (cap_d[0] == CMD_RESET_DONE));
        if (in_fire_i) begin
          if (captured_q < CAP_CNT_W'(CAP_DEPTH)) captured_d = captured_q + CAP_CNT_W'(1);
          pos_d       = pos_q + PW'(1);
          remaining_d = remaining_q - LEN_W'(1);
          if (evt.emit) begin
            state_d      = ST_HEADER;
            pos_d        = '0;
            reset_seen_d = evt.reset_done;
          end else if (pos_q == LAST_PAY_POS) begin
            state_d = ST_CHUNK_HDR;
            pos_d   = '0;
          end
        end
      end

      default: begin
        state_d = ST_HEADER;
        if (pos_q == PW'(3)) begin
          evt.emit   = (packet_len_q <= HDR_BYTES) || (dlen == '0);
          evt.status = (packet_len_q == '0) ? STAT_ZERO_LEN : STAT_EMPTY;
          evt.len    = '0;
          evt.seq    = rx_byte_i;
        end
        if (in_fire_i) begin
          if (pos_q == PW'(0)) begin
            len_low_d = rx_byte_i;
            pos_d     = PW'(1);
          end else if (pos_q == PW'(1)) begin
            packet_len_d = {rx_byte_i[6:0], len_low_q};
            pos_d        = PW'(2);
          end else if (pos_q == PW'(2)) begin
            chan_d = rx_byte_i;
            pos_d  = PW'(3);
          end else begin
            seq_d = rx_byte_i;
            pos_d = '0;
            if (evt.emit) begin
              packet_len_d = '0;
            end else begin
              packet_len_d = dlen;
              remaining_d  = dlen;
              captured_d   = '0;
              state_d      = ST_CHUNK_HDR;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_HEADER;
      pos_q         <= '0;
      len_low_q     <= '0;
      remaining_q   <= '0;
      packet_len_q  <= '0;
      chan_q        <= '0;
      seq_q         <= '0;
      captured_q    <= '0;
      reset_seen_q  <= 1'b0;
      max_payload_q <= MAX_PAYLOAD_RESET;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      len_low_q    <= len_low_d;
      remaining_q  <= remaining_d;
      packet_len_q <= packet_len_d;
      chan_q       <= chan_d;
      seq_q        <= seq_d;
      captured_q   <= captured_d;
      reset_seen_q <= reset_seen_d;
      if (cfg_we_i) max_payload_q <= cfg_wdata_i;
    end
  end

  // capture store has no reset: only entries written by the current packet are read
  always_ff @(posedge clk_i) begin
    cap_q <= cap_d;
  end

  assign evt_o = evt;
  assign cap_o = cap_d;

  a_captured_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    captured_q <= CAP_CNT_W'(CAP_DEPTH))
    else $error("capture count beyond store depth");

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAYLOAD) |-> (remaining_q != '0))
    else $error("payload phase with nothing remaining");

  a_chunk_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAYLOAD) |-> (pos_q <= LAST_PAY_POS))
    else $error("payload position past chunk end");

  a_sticky_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(reset_seen_q) |-> reset_seen_q)
    else $error("reset-done flag cleared");

endmodule

// ===== design/shtp_rvr_decode.sv =====
// Rotation-vector report decode from the captured payload bytes.
// Depends on shtp_rvr_pkg.
module shtp_rvr_decode (
  input  shtp_rvr_pkg::evt_t evt_i,
  input  shtp_rvr_pkg::cap_t cap_i,
  output shtp_rvr_pkg::rot_t rot_o
);
  import shtp_rvr_pkg::*;

  logic ts_lead;
  logic found;
  rot_t rot;

  always_comb begin
    // a leading base-timestamp report moves the rotation vector by five bytes
    ts_lead = (cap_i[0] == ID_TIMESTAMP) && (evt_i.len >= MIN_TS_ROT_LEN);
    found   = (evt_i.status == STAT_PAYLOAD) && (evt_i.chan == CH_SENSOR_RPT) &&
              (evt_i.len >= MIN_ROT_LEN) &&
              (ts_lead ? (cap_i[5] == ID_ROTATION) : (cap_i[0] == ID_ROTATION));

    rot = '0;
    if (found) begin
      rot.valid = 1'b1;
      if (ts_lead) begin
        rot.accuracy  = cap_i[7][1:0];
        rot.quat_i    = {cap_i[11], cap_i[10]};
        rot.quat_j    = {cap_i[13], cap_i[12]};
        rot.quat_k    = {cap_i[15], cap_i[14]};
        rot.quat_real = {cap_i[17], cap_i[16]};
      end else begin
        rot.accuracy  = cap_i[2][1:0];
        rot.quat_i    = {cap_i[6], cap_i[5]};
        rot.quat_j    = {cap_i[8], cap_i[7]};
        rot.quat_k    = {cap_i[10], cap_i[9]};
        rot.quat_real = {cap_i[12], cap_i[11]};
      end
    end
  end

  assign rot_o = rot;

endmodule
